FILE: rtl/core/ira_pkg.sv
// Shared types and constants for the integer to radix ASCII converter.
// No dependencies; used by the interfaces, the divider and the top level.
package ira_pkg;

    localparam int RADIX_BITS = 6;
    localparam int CHAR_BITS  = 7;

    localparam logic [RADIX_BITS-1:0] RADIX_MIN = 6'd2;
    localparam logic [RADIX_BITS-1:0] RADIX_MAX = 6'd36;
    localparam logic [RADIX_BITS-1:0] RADIX_DEC = 6'd10;
    localparam logic [RADIX_BITS-1:0] DIGIT_LETTERS = 6'd10;

    localparam logic [CHAR_BITS-1:0] CHAR_ZERO  = 7'h30;
    localparam logic [CHAR_BITS-1:0] CHAR_A     = 7'h41;
    localparam logic [CHAR_BITS-1:0] CHAR_MINUS = 7'h2D;
    localparam logic [CHAR_BITS-1:0] CHAR_NONE  = 7'h00;

    typedef struct packed {
        logic                  start;
        logic [RADIX_BITS-1:0] divisor;
    } div_ctl_t;

    typedef struct packed {
        logic done;
        logic quo_zero;
    } div_stat_t;

    function automatic logic [CHAR_BITS-1:0] digit_char(input logic [RADIX_BITS-1:0] d);
        logic [CHAR_BITS-1:0] ch;
        if (d < DIGIT_LETTERS)
        begin
            ch = CHAR_ZERO + CHAR_BITS'(d);
        end
        else if (d < RADIX_MAX)
        begin
            ch = CHAR_A + CHAR_BITS'(d - DIGIT_LETTERS);
        end
        else
        begin
            ch = CHAR_ZERO;
        end
        return ch;
    endfunction

endpackage

FILE: rtl/core/ira_in_if.sv
// Request channel carrying the integer and its radix.
// Depends on ira_pkg for the radix width.
interface ira_in_if #(parameter int VALUE_BITS = 32);
    logic                           valid;
    logic                           ready;
    logic signed [VALUE_BITS-1:0]   value;
    logic [ira_pkg::RADIX_BITS-1:0] radix;

    modport source (output valid, output value, output radix, input ready);
    modport sink   (input valid, input value, input radix, output ready);
endinterface

FILE: rtl/core/ira_out_if.sv
// Character channel: one ASCII character per transfer, with last and error flags.
// Depends on ira_pkg for the character width.
interface ira_out_if;
    logic                          valid;
    logic                          ready;
    logic [ira_pkg::CHAR_BITS-1:0] char_code;
    logic                          last;
    logic                          bad_radix;

    modport source (output valid, output char_code, output last, output bad_radix,
                    input ready);
    modport sink   (input valid, input char_code, input last, input bad_radix,
                    output ready);
endinterface

FILE: rtl/core/int_to_radix_ascii_core.sv
// Integer to ASCII string in radix 2..36, most significant digit first.
// Digits come from the bit-serial divider; each character is then read from the digit store
// and emitted, with a leading minus sign for a negative decimal value.
// One request at a time; ready only while idle.
// A bad radix gives a single result character, flagged bad_radix and last.
// Reset clears the sequencer, counts and output valid; the digit store is not cleared.
module int_to_radix_ascii_core #(
    parameter int VALUE_BITS = 32
) (
    input  logic     clk,
    input  logic     rst_n,
    ira_in_if.sink   number,
    ira_out_if.source text
);

    localparam int CNT_BITS = $clog2(VALUE_BITS + 1);
    localparam int IDX_BITS = $clog2(VALUE_BITS);

    typedef enum logic [2:0] {
        S_IDLE,
        S_BAD,
        S_DIV,
        S_SIGN,
        S_READ,
        S_EMIT
    } state_t;

    state_t                          state_reg;
    logic [CNT_BITS-1:0]             cnt_reg;
    logic                            neg_reg;
    logic [ira_pkg::RADIX_BITS-1:0]  radix_reg;
    logic                            out_valid_reg;
    logic [ira_pkg::CHAR_BITS-1:0]   char_reg;
    logic                            last_reg;
    logic                            bad_reg;

    logic [ira_pkg::RADIX_BITS-1:0]  store [VALUE_BITS];
    logic [ira_pkg::RADIX_BITS-1:0]  rd_data_reg;

    ira_pkg::div_ctl_t               div_ctl;
    ira_pkg::div_stat_t              div_stat;
    logic [VALUE_BITS-1:0]           div_dividend;
    logic [VALUE_BITS-1:0]           div_quotient;
    logic [ira_pkg::RADIX_BITS-1:0]  div_remainder;

    logic [VALUE_BITS-1:0]           value_bits;
    logic [VALUE_BITS-1:0]           magnitude;
    logic                            negative;
    logic                            radix_ok;
    logic                            accept;
    logic                            out_free;
    logic                            load_char;
    logic                            wr_en;
    logic [CNT_BITS-1:0]             cnt_m1;
    logic [IDX_BITS-1:0]             rd_idx;
    logic [IDX_BITS-1:0]             wr_idx;

    assign value_bits = number.value;
    assign negative   = (number.radix == ira_pkg::RADIX_DEC) && value_bits[VALUE_BITS-1];
    assign magnitude  = negative ? (~value_bits + 1'b1) : value_bits;
    assign radix_ok   = (number.radix >= ira_pkg::RADIX_MIN)
                     && (number.radix <= ira_pkg::RADIX_MAX);

    assign number.ready = state_reg == S_IDLE;
    assign accept       = number.valid && number.ready;
    assign out_free     = !out_valid_reg || text.ready;
    assign load_char    = out_free && ((state_reg == S_BAD) || (state_reg == S_SIGN)
                                       || (state_reg == S_EMIT));

    assign div_ctl.start   = (accept && radix_ok)
                          || (state_reg == S_DIV && div_stat.done && !div_stat.quo_zero);
    assign div_ctl.divisor = radix_reg;
    assign div_dividend    = (state_reg == S_IDLE) ? magnitude : div_quotient;

    assign wr_en  = state_reg == S_DIV && div_stat.done;
    assign wr_idx = cnt_reg[IDX_BITS-1:0];
    assign cnt_m1 = cnt_reg - 1'b1;
    assign rd_idx = cnt_m1[IDX_BITS-1:0];

    ira_divider #(
        .VALUE_BITS (VALUE_BITS)
    ) u_divider (
        .clk       (clk),
        .rst_n     (rst_n),
        .ctl       (div_ctl),
        .dividend  (div_dividend),
        .stat      (div_stat),
        .quotient  (div_quotient),
        .remainder (div_remainder)
    );

    // Digit store: written least significant first, read back in reverse
    always_ff @(posedge clk)
    begin
        if (wr_en)
        begin
            store[wr_idx] <= div_remainder;
        end
        if (state_reg == S_READ)
        begin
            rd_data_reg <= store[rd_idx];
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= S_IDLE;
            cnt_reg       <= '0;
            neg_reg       <= 1'b0;
            radix_reg     <= '0;
            out_valid_reg <= 1'b0;
            char_reg      <= '0;
            last_reg      <= 1'b0;
            bad_reg       <= 1'b0;
        end
        else
        begin
            if (load_char)
            begin
                out_valid_reg <= 1'b1;
            end
            else if (text.ready)
            begin
                out_valid_reg <= 1'b0;
            end

            unique case (state_reg)
                S_IDLE:
                begin
                    if (accept)
                    begin
                        if (!radix_ok)
                        begin
                            state_reg <= S_BAD;
                        end
                        else
                        begin
                            radix_reg <= number.radix;
                            neg_reg   <= negative;
                            cnt_reg   <= '0;
                            state_reg <= S_DIV;
                        end
                    end
                end
                S_BAD:
                begin
                    if (out_free)
                    begin
                        char_reg      <= ira_pkg::CHAR_NONE;
                        last_reg      <= 1'b1;
                        bad_reg       <= 1'b1;
                        state_reg     <= S_IDLE;
                    end
                end
                S_DIV:
                begin
                    if (div_stat.done)
                    begin
                        cnt_reg <= cnt_reg + 1'b1;
                        if (div_stat.quo_zero)
                        begin
                            state_reg <= neg_reg ? S_SIGN : S_READ;
                        end
                    end
                end
                S_SIGN:
                begin
                    if (out_free)
                    begin
                        char_reg      <= ira_pkg::CHAR_MINUS;
                        last_reg      <= 1'b0;
                        bad_reg       <= 1'b0;
                        state_reg     <= S_READ;
                    end
                end
                S_READ:
                begin
                    state_reg <= S_EMIT;
                end
                S_EMIT:
                begin
                    if (out_free)
                    begin
                        char_reg      <= ira_pkg::digit_char(rd_data_reg);
                        last_reg      <= cnt_reg == CNT_BITS'(1);
                        bad_reg       <= 1'b0;
                        cnt_reg       <= cnt_m1;
                        state_reg     <= (cnt_reg == CNT_BITS'(1)) ? S_IDLE : S_READ;
                    end
                end
                default:
                begin
                    state_reg <= S_IDLE;
                end
            endcase
        end
    end

    assign text.valid     = out_valid_reg;
    assign text.char_code = char_reg;
    assign text.last      = last_reg;
    assign text.bad_radix = bad_reg;

endmodule

FILE: rtl/core/ira_divider.sv
// Bit-serial restoring divider: VALUE_BITS-wide dividend by a 6-bit radix.
// One quotient bit per cycle; depends on ira_pkg for the control structs.
module ira_divider #(
    parameter int VALUE_BITS = 32
) (
    input  logic                           clk,
    input  logic                           rst_n,
    input  ira_pkg::div_ctl_t              ctl,
    input  logic [VALUE_BITS-1:0]          dividend,
    output ira_pkg::div_stat_t             stat,
    output logic [VALUE_BITS-1:0]          quotient,
    output logic [ira_pkg::RADIX_BITS-1:0] remainder
);

    localparam int CNT_BITS = $clog2(VALUE_BITS + 1);

    logic [VALUE_BITS-1:0]          quo_reg;
    logic [ira_pkg::RADIX_BITS-1:0] rem_reg;
    logic [CNT_BITS-1:0]            cnt_reg;
    logic                           busy_reg;
    logic                           done_reg;

    logic [ira_pkg::RADIX_BITS:0]   trial;
    logic                           fits;
    logic [ira_pkg::RADIX_BITS:0]   diff;

    assign trial = {rem_reg, quo_reg[VALUE_BITS-1]};
    assign fits  = trial >= {1'b0, ctl.divisor};
    assign diff  = trial - {1'b0, ctl.divisor};

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            quo_reg  <= '0;
            rem_reg  <= '0;
            cnt_reg  <= '0;
            busy_reg <= 1'b0;
            done_reg <= 1'b0;
        end
        else if (ctl.start)
        begin
            quo_reg  <= dividend;
            rem_reg  <= '0;
            cnt_reg  <= CNT_BITS'(VALUE_BITS);
            busy_reg <= 1'b1;
            done_reg <= 1'b0;
        end
        else if (busy_reg)
        begin
            quo_reg  <= {quo_reg[VALUE_BITS-2:0], fits};
            rem_reg  <= fits ? diff[ira_pkg::RADIX_BITS-1:0]
                             : trial[ira_pkg::RADIX_BITS-1:0];
            cnt_reg  <= cnt_reg - 1'b1;
            busy_reg <= cnt_reg != CNT_BITS'(1);
            done_reg <= cnt_reg == CNT_BITS'(1);
        end
        else
        begin
            done_reg <= 1'b0;
        end
    end

    assign stat.done     = done_reg;
    assign stat.quo_zero = quo_reg == '0;
    assign quotient      = quo_reg;
    assign remainder     = rem_reg;

endmodule
